@@ src/sat_pkg.sv @@
// ----------------------------------------------------------------------------
// sat_pkg
// shared types and constants of the sorted alarm timer queue
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int SlotsDef    = 16;
  localparam int TimeBitsDef = 32;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_REARM  = 3'd3,
    OP_PEEK   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INSERT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE,
    CM_SETEXP
  } cmd_t;

  typedef struct packed {
    logic prior;
    logic rm;
    logic match;
  } link_t;

endpackage

@@ src/sat_if.sv @@
// ----------------------------------------------------------------------------
// sat_in_if / sat_out_if
// request and result channels of the alarm timer queue
// ----------------------------------------------------------------------------
interface sat_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [3:0]  slot;
  logic [7:0]  owner;
  logic [31:0] interval;
  logic [7:0]  alarm_flags;
  logic [31:0] now_ms;
  modport source (output valid, op, slot, owner, interval, alarm_flags, now_ms,
                  input ready);
  modport sink   (input valid, op, slot, owner, interval, alarm_flags, now_ms,
                  output ready);
endinterface

interface sat_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [3:0]  handle;
  logic        head_valid;
  logic [31:0] head_time;
  modport source (output valid, status, handle, head_valid, head_time, input ready);
  modport sink   (input valid, status, handle, head_valid, head_time, output ready);
endinterface

@@ src/sat_cell.sv @@
// ----------------------------------------------------------------------------
// sat_cell
// one list position: slot id and expiry, shifts with its neighbors
// ----------------------------------------------------------------------------
module sat_cell #(
  parameter int IDX_W     = 4,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sat_pkg::cmd_t        cmd,
  input  logic [IDX_W-1:0]     key,
  input  logic [IDX_W-1:0]     new_slot,
  input  logic [TIME_BITS-1:0] new_exp,
  input  logic                 left_valid,
  input  logic [IDX_W-1:0]     left_slot,
  input  logic [TIME_BITS-1:0] left_exp,
  input  logic                 right_valid,
  input  logic [IDX_W-1:0]     right_slot,
  input  logic [TIME_BITS-1:0] right_exp,
  input  sat_pkg::link_t       lk_in,
  output sat_pkg::link_t       lk_out,
  output logic                 valid,
  output logic [IDX_W-1:0]     slot,
  output logic [TIME_BITS-1:0] exp_t,
  output logic                 succ_gt
);
  import sat_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [TIME_BITS-1:0] exp_r, exp_nxt;
  logic                 match, hit, at_pos;

  assign match  = valid_r && (slot_r == key);
  assign hit    = valid_r && (exp_r > new_exp);
  assign at_pos = !lk_in.prior && (hit || !valid_r);

  assign lk_out.prior  = lk_in.prior | hit | !valid_r;
  assign lk_out.rm     = lk_in.rm | match;
  assign lk_out.match  = match;
  assign succ_gt       = lk_in.match && valid_r && (new_exp > exp_r);

  always_comb begin
    valid_nxt = valid_r;
    slot_nxt  = slot_r;
    exp_nxt   = exp_r;
    case (cmd)
      CM_INSERT: begin
        if (lk_in.prior) begin
          valid_nxt = left_valid;
          slot_nxt  = left_slot;
          exp_nxt   = left_exp;
        end else if (at_pos) begin
          valid_nxt = 1'b1;
          slot_nxt  = new_slot;
          exp_nxt   = new_exp;
        end
      end
      CM_REMOVE: begin
        if (lk_in.rm || match) begin
          valid_nxt = right_valid;
          slot_nxt  = right_slot;
          exp_nxt   = right_exp;
        end
      end
      CM_SETEXP: begin
        if (match) exp_nxt = new_exp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
    slot_r <= slot_nxt;
    exp_r  <= exp_nxt;
  end

  assign valid = valid_r;
  assign slot  = slot_r;
  assign exp_t = exp_r;
endmodule

@@ src/sorted_alarm_timer_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue
// alarm slots kept in list order by a chain of position cells
//
//   channel | dir | fields
//   in_ch   | in  | op, slot, owner, interval, alarm_flags, now_ms
//   out_ch  | out | status, handle, head_valid, head_time
//
// one request at a time: add, update and a moving rearm go through the check
// and insert states (update and rearm unlink in check); the rest go from check
// straight to done, and the block returns to idle once the result is taken.
// synchronous reset empties the chain and frees all slots.
// a stalled result holds the block; no request is taken until it leaves.
// ----------------------------------------------------------------------------
module sorted_alarm_timer_queue
  import sat_pkg::*;
#(
  parameter int SLOTS     = sat_pkg::SlotsDef,
  parameter int TIME_BITS = sat_pkg::TimeBitsDef
) (
  input logic       clk,
  input logic       rst_n,
  sat_in_if.sink    in_ch,
  sat_out_if.source out_ch
);
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CELLS = SLOTS - 1;

  state_t state_r, state_nxt;

  logic [2:0]           op_r;
  logic [3:0]           key_r;
  logic [7:0]           own_r;
  logic [TIME_BITS-1:0] ivl_r;
  logic [7:0]           fl_r;
  logic [TIME_BITS-1:0] now_r;

  logic [7:0]           flags_r  [SLOTS];
  logic [7:0]           owner_r  [SLOTS];
  logic [TIME_BITS-1:0] period_r [SLOTS];

  logic                 ok_r, ok_nxt;
  logic [IDX_W-1:0]     tgt_r, tgt_nxt;
  logic [TIME_BITS-1:0] nexp_r, nexp_nxt;
  logic                 ins_nxt;

  logic                 inrange, found, ok_c;
  logic [IDX_W-1:0]     kidx, free_idx;
  logic [7:0]           kflags, kowner;
  logic [TIME_BITS-1:0] kperiod;
  logic                 any_gt;

  cmd_t                 cmd;
  logic [IDX_W-1:0]     ckey;
  logic [TIME_BITS-1:0] cexp;

  logic                 c_valid [CELLS+1];
  logic [IDX_W-1:0]     c_slot  [CELLS+1];
  logic [TIME_BITS-1:0] c_exp   [CELLS+1];
  link_t                c_lk    [CELLS+1];
  logic [CELLS-1:0]     c_gt;

  assign inrange = 32'(key_r) < 32'(SLOTS);
  assign kidx    = IDX_W'(key_r);
  assign kflags  = flags_r[kidx];
  assign kowner  = owner_r[kidx];
  assign kperiod = period_r[kidx];
  assign any_gt  = |c_gt;

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 1; i--) begin
      if (flags_r[i] == 8'd0) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // request checks and chain command
  always_comb begin
    ok_c     = 1'b0;
    tgt_nxt  = tgt_r;
    nexp_nxt = nexp_r;
    ins_nxt  = 1'b0;
    ckey     = kidx;
    cexp     = nexp_r;
    cmd      = CM_HOLD;
    if (state_r == ST_CHECK) begin
      unique case (op_r)
        OP_ADD: begin
          ok_c     = (fl_r != 8'd0) && found;
          tgt_nxt  = free_idx;
          nexp_nxt = now_r + ivl_r;
          ins_nxt  = ok_c;
        end
        OP_DELETE: begin
          ok_c    = inrange && (kflags != 8'd0) && (kowner == own_r);
          tgt_nxt = kidx;
          if (ok_c) cmd = CM_REMOVE;
        end
        OP_UPDATE: begin
          ok_c     = inrange && (kflags != 8'd0) && (kowner == own_r) && (fl_r != 8'd0);
          tgt_nxt  = kidx;
          nexp_nxt = now_r + ivl_r;
          ins_nxt  = ok_c;
          if (ok_c) cmd = CM_REMOVE;
        end
        OP_REARM: begin
          ok_c     = inrange && kflags[0] && (kowner == own_r);
          tgt_nxt  = kidx;
          nexp_nxt = now_r + kperiod;
          cexp     = nexp_nxt;
          ins_nxt  = ok_c && any_gt;
          if (ok_c) cmd = any_gt ? CM_REMOVE : CM_SETEXP;
        end
        OP_PEEK: begin
          ok_c    = 1'b1;
          tgt_nxt = '0;
        end
        default: ok_c = 1'b0;
      endcase
    end else if (state_r == ST_INSERT) begin
      cmd  = CM_INSERT;
      cexp = nexp_r;
    end
    ok_nxt = (state_r == ST_CHECK) ? ok_c : ok_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = ins_nxt ? ST_INSERT : ST_DONE;
      ST_INSERT: state_nxt = ST_DONE;
      ST_DONE:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready       = (state_r == ST_IDLE);
    out_ch.valid      = (state_r == ST_DONE);
    out_ch.status     = !ok_r;
    out_ch.handle     = ok_r ? 4'(tgt_r) : 4'd0;
    out_ch.head_valid = c_valid[0];
    out_ch.head_time  = c_valid[0] ? 32'(c_exp[0]) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ok_r    <= ok_nxt;
    end
    tgt_r  <= tgt_nxt;
    nexp_r <= nexp_nxt;
    if (state_r == ST_IDLE && in_ch.valid) begin
      op_r  <= in_ch.op;
      key_r <= in_ch.slot;
      own_r <= in_ch.owner;
      ivl_r <= TIME_BITS'(in_ch.interval);
      fl_r  <= in_ch.alarm_flags;
      now_r <= TIME_BITS'(in_ch.now_ms);
    end
  end

  // slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        flags_r[i] <= 8'd0;
        owner_r[i] <= 8'd0;
      end
    end else if (state_r == ST_CHECK && ok_c) begin
      unique case (op_r)
        OP_ADD: begin
          flags_r[free_idx]  <= fl_r;
          owner_r[free_idx]  <= own_r;
          period_r[free_idx] <= ivl_r;
        end
        OP_DELETE: begin
          flags_r[kidx] <= 8'd0;
          owner_r[kidx] <= 8'd0;
        end
        OP_UPDATE: begin
          flags_r[kidx]  <= fl_r;
          period_r[kidx] <= ivl_r;
        end
        OP_REARM: flags_r[kidx] <= kflags & 8'hFD;
        default: ;
      endcase
    end
  end

  // list order
  assign c_lk[0]             = '0;
  assign c_valid[CELLS]      = 1'b0;
  assign c_slot[CELLS]       = '0;
  assign c_exp[CELLS]        = '0;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    sat_cell #(
      .IDX_W     (IDX_W),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .key         (ckey),
      .new_slot    (tgt_r),
      .new_exp     (cexp),
      .left_valid  ((g == 0) ? 1'b0 : c_valid[(g == 0) ? 0 : g - 1]),
      .left_slot   (c_slot[(g == 0) ? 0 : g - 1]),
      .left_exp    (c_exp[(g == 0) ? 0 : g - 1]),
      .right_valid (c_valid[g + 1]),
      .right_slot  (c_slot[g + 1]),
      .right_exp   (c_exp[g + 1]),
      .lk_in       (c_lk[g]),
      .lk_out      (c_lk[g + 1]),
      .valid       (c_valid[g]),
      .slot        (c_slot[g]),
      .exp_t       (c_exp[g]),
      .succ_gt     (c_gt[g])
    );
  end
endmodule

@@ sim/sorted_alarm_timer_queue_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue_tb
// drives add, delete, update, rearm and peek requests into the alarm queue,
// predicts each result from a local copy of the sorted slot list and compares
// status, handle and earliest expiry field by field
// ----------------------------------------------------------------------------
module sorted_alarm_timer_queue_tb;
  import sat_pkg::*;

  localparam int NSLOT = 16;
  localparam int WDOG = 5000;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [7:0]  owner;
    logic [31:0] interval;
    logic [7:0]  alarm_flags;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  handle;
    logic        head_valid;
    logic [31:0] head_time;
  } alarm_rsp_t;

  logic clk = 0;
  logic rst_n = 0;

  sat_in_if  in_ch();
  sat_out_if out_ch();

  sorted_alarm_timer_queue uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  req_t       pending_reqs[$];
  alarm_rsp_t expected_rsps[$];

  logic [3:0]  lnk[NSLOT];
  logic [31:0] expiry[NSLOT];
  logic [31:0] per[NSLOT];
  logic [7:0]  flg[NSLOT];
  logic [7:0]  own[NSLOT];

  int errors = 0;
  int n_sent = 0;
  int n_rsp = 0;
  int n_rej = 0;
  int idle_cnt = 0;
  bit idle_on = 1;
  bit hold_sender = 0;
  bit stim_done = 0;
  bit in_taken = 0;
  logic [31:0] clock_ms = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void list_unlink(int s);
    int p;
    p = 0;
    for (int n = 0; n < NSLOT; n++) begin
      if (lnk[p] == s) begin
        lnk[p] = lnk[s];
        return;
      end
      if (lnk[p] == 0) return;
      p = lnk[p];
    end
  endfunction

  function automatic void list_insert(int s);
    int p;
    int q;
    p = 0;
    for (int n = 0; n < NSLOT; n++) begin
      q = lnk[p];
      if (q == 0 || expiry[q] > expiry[s]) break;
      p = q;
    end
    lnk[s] = lnk[p];
    lnk[p] = s[3:0];
  endfunction

  function automatic alarm_rsp_t queue_step(req_t r);
    alarm_rsp_t res;
    int i;
    int k;
    int nx;
    bit ok;
    ok = 0;
    k = r.slot;
    res.handle = 0;
    case (r.op)
      OP_ADD: begin
        if (r.alarm_flags != 0) begin
          i = 1;
          while (i < NSLOT && flg[i] != 0) i++;
          if (i < NSLOT) begin
            per[i] = r.interval;
            flg[i] = r.alarm_flags;
            expiry[i] = r.now_ms + r.interval;
            own[i] = r.owner;
            lnk[i] = 0;
            list_insert(i);
            ok = 1;
            res.handle = i[3:0];
          end
        end
      end
      OP_DELETE: begin
        if (flg[k] != 0 && own[k] == r.owner) begin
          list_unlink(k);
          lnk[k] = 0;
          flg[k] = 0;
          own[k] = 0;
          ok = 1;
          res.handle = k[3:0];
        end
      end
      OP_UPDATE: begin
        if (flg[k] != 0 && own[k] == r.owner && r.alarm_flags != 0) begin
          list_unlink(k);
          per[k] = r.interval;
          expiry[k] = r.now_ms + r.interval;
          flg[k] = r.alarm_flags;
          lnk[k] = 0;
          list_insert(k);
          ok = 1;
          res.handle = k[3:0];
        end
      end
      OP_REARM: begin
        if (flg[k][0] && own[k] == r.owner) begin
          expiry[k] = r.now_ms + per[k];
          flg[k] = flg[k] & 8'hFD;
          nx = lnk[k];
          if (nx != 0 && expiry[k] > expiry[nx]) begin
            list_unlink(k);
            lnk[k] = 0;
            list_insert(k);
          end
          ok = 1;
          res.handle = k[3:0];
        end
      end
      OP_PEEK: ok = 1;
      default: ok = 0;
    endcase
    res.status = !ok;
    res.head_valid = lnk[0] != 0;
    res.head_time = (lnk[0] != 0) ? expiry[lnk[0]] : 32'd0;
    return res;
  endfunction

  // second predictor copy, separate from the stimulus shadow
  logic [3:0]  m_lnk[NSLOT];
  logic [31:0] m_exp[NSLOT];
  logic [31:0] m_per[NSLOT];
  logic [7:0]  m_flg[NSLOT];
  logic [7:0]  m_own[NSLOT];

  function automatic alarm_rsp_t model_step(req_t r);
    logic [3:0]  s_lnk[NSLOT];
    logic [31:0] s_exp[NSLOT];
    logic [31:0] s_per[NSLOT];
    logic [7:0]  s_flg[NSLOT];
    logic [7:0]  s_own[NSLOT];
    alarm_rsp_t res;
    s_lnk = lnk; s_exp = expiry; s_per = per; s_flg = flg; s_own = own;
    lnk = m_lnk; expiry = m_exp; per = m_per; flg = m_flg; own = m_own;
    res = queue_step(r);
    m_lnk = lnk; m_exp = expiry; m_per = per; m_flg = flg; m_own = own;
    lnk = s_lnk; expiry = s_exp; per = s_per; flg = s_flg; own = s_own;
    return res;
  endfunction

  // used slot picked at random, or any slot
  function automatic logic [3:0] pick_slot();
    logic [3:0] s;
    for (int t = 0; t < 8; t++) begin
      s = 4'($urandom_range(1, NSLOT - 1));
      if (flg[s] != 0) return s;
    end
    return 4'($urandom_range(0, NSLOT - 1));
  endfunction

  function automatic req_t make_req(logic [2:0] op, logic [3:0] slot, logic [7:0] owner,
                                    logic [31:0] ivl, logic [7:0] fl, logic [31:0] now);
    req_t r;
    r.op = op;
    r.slot = slot;
    r.owner = owner;
    r.interval = ivl;
    r.alarm_flags = fl;
    r.now_ms = now;
    return r;
  endfunction

  task automatic push_req(req_t r);
    pending_reqs.push_back(r);
  endtask

  // random requests, mostly valid against a shadow of the slot table
  task automatic push_random(int cnt);
    req_t r;
    logic [3:0] s;
    int kind;
    for (int n = 0; n < cnt; n++) begin
      while (pending_reqs.size() > 4) @(posedge clk);
      clock_ms = clock_ms + $urandom_range(0, 50);
      kind = $urandom_range(0, 99);
      s = pick_slot();
      r = make_req(OP_PEEK, s, own[s], 32'($urandom_range(0, 1000)),
                   8'($urandom_range(1, 255)), clock_ms);
      if ($urandom_range(0, 15) == 0) r.interval = $urandom;
      if ($urandom_range(0, 15) == 0) r.now_ms = $urandom;
      if (kind < 35) begin
        r.op = OP_ADD;
        r.owner = 8'($urandom);
      end else if (kind < 50) r.op = OP_DELETE;
      else if (kind < 62) r.op = OP_UPDATE;
      else if (kind < 80) r.op = OP_REARM;
      else if (kind < 86) r.op = OP_PEEK;
      else if (kind < 90) r.op = 3'($urandom_range(5, 7));
      else begin
        r.op = 3'($urandom_range(0, 3));
        r.owner = 8'($urandom);
        r.slot = 4'($urandom);
        if ($urandom_range(0, 1)) r.alarm_flags = 0;
      end
      if (kind < 80 && $urandom_range(0, 20) == 0) r.alarm_flags = 0;
      if (r.op == OP_ADD || r.op == OP_UPDATE) begin
        if ($urandom_range(0, 1)) r.alarm_flags[0] = 1;
      end
      // keep the shadow in step so later picks see the new table
      void'(queue_step(r));
      push_req(r);
    end
  endtask

  // request taken at the last rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
    end else begin
      if (in_taken) n_sent <= n_sent + 1;
      if (!in_ch.valid || in_taken) begin
        if (pending_reqs.size() > 0 && !hold_sender &&
            !(idle_on && $urandom_range(0, 99) < 30)) begin
          {in_ch.op, in_ch.slot, in_ch.owner, in_ch.interval, in_ch.alarm_flags,
           in_ch.now_ms} <= pending_reqs.pop_front();
          in_ch.valid <= 1;
        end else begin
          in_ch.valid <= 0;
        end
      end
      out_ch.ready <= !(idle_on && $urandom_range(0, 99) < 30);
    end
  end

  // monitor: prediction on acceptance, comparison on results
  req_t exp_req;
  alarm_rsp_t got;
  alarm_rsp_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (in_ch.valid && in_ch.ready) begin
        exp_req = {in_ch.op, in_ch.slot, in_ch.owner, in_ch.interval, in_ch.alarm_flags,
                   in_ch.now_ms};
        expected_rsps.push_back(model_step(exp_req));
      end
      if (out_ch.valid && out_ch.ready) begin
        n_rsp <= n_rsp + 1;
        got = {out_ch.status, out_ch.handle, out_ch.head_valid, out_ch.head_time};
        if (got.status) n_rej <= n_rej + 1;
        if (expected_rsps.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_rsps.pop_front();
          if (got.status !== want.status || got.handle !== want.handle ||
              got.head_valid !== want.head_valid || got.head_time !== want.head_time) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("mismatch: status %0d/%0d handle %0d/%0d head %0d/%0d time %h/%h",
                       want.status, got.status, want.handle, got.handle,
                       want.head_valid, got.head_valid, want.head_time, got.head_time);
          end
        end
      end
      if (idle_cnt > WDOG) begin
        $display("sorted_alarm_timer_queue regression: fail");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.op = 0;
    in_ch.slot = 0;
    in_ch.owner = 0;
    in_ch.interval = 0;
    in_ch.alarm_flags = 0;
    in_ch.now_ms = 0;
    out_ch.ready = 0;
    for (int i = 0; i < NSLOT; i++) begin
      lnk[i] = 0; expiry[i] = 0; per[i] = 0; flg[i] = 0; own[i] = 0;
      m_lnk[i] = 0; m_exp[i] = 0; m_per[i] = 0; m_flg[i] = 0; m_own[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: empty peek, fill to full, equal times, extremes, slot zero, bad ops
    begin
      req_t d[$];
      d.push_back(make_req(OP_PEEK, 0, 0, 0, 0, 0));
      d.push_back(make_req(OP_ADD, 0, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
      d.push_back(make_req(OP_ADD, 0, 8'h00, 32'd0, 8'h00, 32'd5));
      d.push_back(make_req(OP_ADD, 0, 8'h11, 32'd10, 8'h01, 32'd0));
      d.push_back(make_req(OP_ADD, 0, 8'h22, 32'd10, 8'h03, 32'd0));
      d.push_back(make_req(OP_DELETE, 0, 8'h00, 0, 8'h01, 0));
      d.push_back(make_req(OP_UPDATE, 0, 8'h00, 5, 8'h01, 0));
      d.push_back(make_req(OP_REARM, 0, 8'h00, 0, 8'h01, 0));
      d.push_back(make_req(OP_REARM, 2, 8'h22, 0, 8'h01, 32'd100));
      d.push_back(make_req(OP_REARM, 3, 8'h22, 0, 8'h01, 32'd0));
      d.push_back(make_req(OP_DELETE, 2, 8'h99, 0, 8'h01, 0));
      d.push_back(make_req(OP_UPDATE, 2, 8'h22, 3, 8'h00, 0));
      d.push_back(make_req(OP_UPDATE, 2, 8'h22, 3, 8'h80, 32'hFFFF_FFFF));
      d.push_back(make_req(3'd5, 1, 0, 0, 8'h01, 0));
      d.push_back(make_req(3'd6, 1, 0, 0, 8'h01, 0));
      d.push_back(make_req(3'd7, 15, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
      for (int i = 0; i < 14; i++)
        d.push_back(make_req(OP_ADD, 0, i[7:0], i * 3, 8'h01, 32'd1));
      d.push_back(make_req(OP_DELETE, 15, 8'h0C, 0, 8'h01, 0));
      foreach (d[j]) begin
        void'(queue_step(d[j]));
        push_req(d[j]);
      end
    end
    drain();
    // empty the table so random traffic starts from scratch
    for (int i = 1; i < NSLOT; i++)
      if (flg[i] != 0) begin
        req_t r;
        r = make_req(OP_DELETE, i[3:0], own[i], 0, 8'h01, 0);
        void'(queue_step(r));
        push_req(r);
      end
    drain();

    idle_on = 0;
    push_random(150);
    drain();
    idle_on = 1;
    push_random(300);
    // sender holds until every result is back
    hold_sender = 1;
    while (in_ch.valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
    hold_sender = 0;
    push_random(350);
    drain();
    stim_done = 1;

    $display("requests sent %0d, results checked %0d, rejected %0d, mismatches %0d",
             n_sent, n_rsp, n_rej, errors);
    if (errors == 0) begin
      $display("sorted_alarm_timer_queue regression: pass");
    end else begin
      $display("sorted_alarm_timer_queue regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/sat_pkg.sv
src/sat_if.sv
src/sat_cell.sv
src/sorted_alarm_timer_queue.sv
sim/sorted_alarm_timer_queue_tb.sv
